FILE: sv/scfl_pkg.sv
// Shared types and constants for the size class free list allocator.
`timescale 1ns / 1ps

package scfl_pkg;

    localparam int POOL_GRANULES = 4096;
    localparam int NUM_CLASSES   = 16;
    localparam int REFILL_BLOCKS = 20;
    localparam int GRANULE_BYTES = 8;

    localparam int GW = 13;  // granule address incl. empty marker
    localparam int LW = 12;  // link store index

    localparam logic [GW-1:0] EMPTY_MARK = GW'(POOL_GRANULES);
    localparam logic [7:0]    MAX_BYTES  = 8'(NUM_CLASSES * GRANULE_BYTES);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OUT_OF_MEM = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_CARVE,
        S_DIV,
        S_SEARCH,
        S_SPOP,
        S_CHAIN
    } state_t;

endpackage

FILE: sv/scfl_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps

module scfl_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/size_class_free_list_allocator.sv
// Top level of the size class free list allocator.
// Free and bad size beats finish in the idle state, a list pop in the pop state after it.
// A refill takes up to 4 carve rounds, a remainder divide by repeated subtraction, a list
// search upward when the heap cannot grow, then one link write per chained block.
// One beat is in flight at a time; the link store RAM port paces the work.
// Reset empties all lists and clears pool and heap pointers; the link store is not cleared.
`timescale 1ns / 1ps

module size_class_free_list_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_size[7:0], free_addr[22:8], zero[23]
    input  logic        s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // block_addr[14:0], status[16:15], zero[23:17]
);

    import scfl_pkg::*;

    state_t state_reg, state_next;

    logic [GW-1:0] heads_reg [NUM_CLASSES];
    logic [GW-1:0] heads_next [NUM_CLASSES];
    logic [GW-1:0] pool_start_reg, pool_start_next;
    logic [GW-1:0] pool_end_reg, pool_end_next;
    logic [GW-1:0] heap_top_reg, heap_top_next;
    logic [GW-1:0] heap_total_reg, heap_total_next;
    logic [4:0]    n_reg, n_next;
    logic [3:0]    cls_reg, cls_next;
    logic [4:0]    count_reg, count_next;
    logic [1:0]    round_reg, round_next;
    logic [GW-1:0] at_reg, at_next;
    logic [GW-1:0] cur_reg, cur_next;
    logic [4:0]    idx_reg, idx_next;      // chain index or search class
    logic [8:0]    rem_reg, rem_next;
    logic [4:0]    quot_reg, quot_next;
    logic [GW-1:0] hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    logic [14:0]   out_addr_reg, out_addr_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic          ram_we;
    logic [LW-1:0] ram_waddr, ram_raddr;
    logic [GW-1:0] ram_wdata, ram_rdata;

    logic          accept;
    logic          in_cmd;
    logic [7:0]    in_size;
    logic [14:0]   in_faddr;
    logic          in_bad;
    logic [4:0]    in_n;
    logic [3:0]    in_cls;
    logic [3:0]    head_idx;
    logic [GW-1:0] head_rd;
    logic [8:0]    total;
    logic [GW-1:0] left;
    logic          fit_all, fit_one;
    logic [8:0]    extra;
    logic [10:0]   get;
    logic [GW-1:0] avail;
    logic          grow_ok;
    logic          done;
    logic [1:0]    done_status;
    logic [GW-1:0] div_take;

    scfl_ram #(.WIDTH(GW), .DEPTH(POOL_GRANULES)) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_cmd   = s_axis_tuser;
    assign in_size  = s_axis_tdata[7:0];
    assign in_faddr = s_axis_tdata[22:8];
    assign in_bad   = (in_size == 8'd0) || (in_size > MAX_BYTES);
    assign in_n     = 5'((9'(in_size) + 9'(GRANULE_BYTES - 1)) >> 3);
    assign in_cls   = 4'(in_n - 5'd1);

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign total    = 9'(10'(n_reg) * 10'(count_reg));
    assign left     = (pool_end_reg >= pool_start_reg) ? pool_end_reg - pool_start_reg : '0;
    assign fit_all  = left >= GW'(total);
    assign fit_one  = left >= GW'(n_reg);
    assign extra    = 9'((GW'(heap_total_reg >> 1) + GW'(GRANULE_BYTES - 1)) >> 3);
    assign get      = 11'({total, 1'b0}) + 11'(extra);
    assign avail    = GW'(POOL_GRANULES) - heap_top_reg;
    assign grow_ok  = GW'(get) <= avail;
    assign div_take = GW'(10'(n_reg) * 10'(quot_reg));

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   head_idx = in_cls;
            S_CARVE:  head_idx = 4'(left - GW'(1));
            S_SEARCH: head_idx = 4'(idx_reg - 5'd1);
            S_SPOP:   head_idx = 4'(idx_reg - 5'd1);
            default:  head_idx = cls_reg;
        endcase
    end

    assign head_rd = heads_reg[head_idx];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !in_bad && !in_cmd)
                begin
                    state_next = (head_rd != EMPTY_MARK) ? S_POP : S_CARVE;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            S_CARVE:
            begin
                priority if (fit_all)
                begin
                    state_next = S_CHAIN;
                end
                else if (fit_one)
                begin
                    state_next = S_DIV;
                end
                else if (grow_ok)
                begin
                    state_next = (round_reg == 2'd3) ? S_IDLE : S_CARVE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_DIV:
            begin
                if (rem_reg < 9'(n_reg))
                begin
                    state_next = S_CHAIN;
                end
            end
            S_SEARCH:
            begin
                priority if (head_rd != EMPTY_MARK)
                begin
                    state_next = S_SPOP;
                end
                else if (idx_reg == 5'(NUM_CLASSES))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPOP:
            begin
                state_next = (round_reg == 2'd3) ? S_IDLE : S_CARVE;
            end
            S_CHAIN:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Granules at or past the end of the backing region have no link entry:
    // writes to them are dropped and reads give zero.
    always_comb
    begin
        heads_next      = heads_reg;
        pool_start_next = pool_start_reg;
        pool_end_next   = pool_end_reg;
        heap_top_next   = heap_top_reg;
        heap_total_next = heap_total_reg;
        n_next          = n_reg;
        cls_next        = cls_reg;
        count_next      = count_reg;
        round_next      = round_reg;
        at_next         = at_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        hit_next        = hit_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        done            = 1'b0;
        done_status     = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next     = in_n;
                    cls_next   = in_cls;
                    count_next = 5'(REFILL_BLOCKS);
                    round_next = '0;
                    at_next    = head_rd;
                    ram_raddr  = head_rd[LW-1:0];
                    priority if (in_bad)
                    begin
                        done        = 1'b1;
                        done_status = ST_BAD_SIZE;
                        at_next     = '0;
                    end
                    else if (in_cmd)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = in_faddr[14:3];
                        ram_wdata        = head_rd;
                        heads_next[in_cls] = GW'(in_faddr[14:3]);
                        done             = 1'b1;
                        at_next          = '0;
                    end
                end
            end
            S_POP:
            begin
                heads_next[cls_reg] = at_reg[LW] ? '0 : ram_rdata;
                done                = 1'b1;
            end
            S_CARVE:
            begin
                priority if (fit_all)
                begin
                    at_next         = pool_start_reg;
                    pool_start_next = pool_start_reg + GW'(total);
                    cur_next        = pool_start_reg + GW'(n_reg);
                    idx_next        = 5'd1;
                end
                else if (fit_one)
                begin
                    rem_next  = 9'(left);
                    quot_next = '0;
                end
                else
                begin
                    if (left != '0)
                    begin
                        ram_we               = !pool_start_reg[LW];
                        ram_waddr            = pool_start_reg[LW-1:0];
                        ram_wdata            = head_rd;
                        heads_next[head_idx] = pool_start_reg;
                    end
                    pool_start_next = pool_end_reg;
                    if (grow_ok)
                    begin
                        pool_start_next = heap_top_reg;
                        heap_top_next   = heap_top_reg + GW'(get);
                        pool_end_next   = heap_top_reg + GW'(get);
                        heap_total_next = heap_total_reg + GW'(get);
                        round_next      = round_reg + 2'd1;
                        if (round_reg == 2'd3)
                        begin
                            done        = 1'b1;
                            done_status = ST_OUT_OF_MEM;
                            at_next     = '0;
                        end
                    end
                    else
                    begin
                        idx_next = n_reg;
                    end
                end
            end
            S_DIV:
            begin
                if (rem_reg >= 9'(n_reg))
                begin
                    rem_next  = rem_reg - 9'(n_reg);
                    quot_next = quot_reg + 5'd1;
                end
                else
                begin
                    count_next      = quot_reg;
                    at_next         = pool_start_reg;
                    pool_start_next = pool_start_reg + div_take;
                    cur_next        = pool_start_reg + GW'(n_reg);
                    idx_next        = 5'd1;
                end
            end
            S_SEARCH:
            begin
                priority if (head_rd != EMPTY_MARK)
                begin
                    hit_next  = head_rd;
                    ram_raddr = head_rd[LW-1:0];
                end
                else if (idx_reg == 5'(NUM_CLASSES))
                begin
                    pool_start_next = '0;
                    pool_end_next   = '0;
                    done            = 1'b1;
                    done_status     = ST_OUT_OF_MEM;
                    at_next         = '0;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            S_SPOP:
            begin
                heads_next[head_idx] = hit_reg[LW] ? '0 : ram_rdata;
                pool_start_next      = hit_reg;
                pool_end_next        = hit_reg + GW'(idx_reg);
                round_next           = round_reg + 2'd1;
                if (round_reg == 2'd3)
                begin
                    done        = 1'b1;
                    done_status = ST_OUT_OF_MEM;
                    at_next     = '0;
                end
            end
            S_CHAIN:
            begin
                if (idx_reg < count_reg)
                begin
                    if (idx_reg == 5'd1)
                    begin
                        heads_next[cls_reg] = at_reg + GW'(n_reg);
                    end
                    ram_we    = !cur_reg[LW];
                    ram_waddr = cur_reg[LW-1:0];
                    ram_wdata = (idx_reg == count_reg - 5'd1) ? EMPTY_MARK
                                                              : cur_reg + GW'(n_reg);
                    cur_next  = cur_reg + GW'(n_reg);
                    idx_next  = idx_reg + 5'd1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        if (done)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = 15'({at_next[LW-1:0], 3'b000});
            out_status_next = done_status;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_status_reg, out_addr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pool_start_reg <= '0;
            pool_end_reg   <= '0;
            heap_top_reg   <= '0;
            heap_total_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= EMPTY_MARK;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pool_start_reg <= pool_start_next;
            pool_end_reg   <= pool_end_next;
            heap_top_reg   <= heap_top_next;
            heap_total_reg <= heap_total_next;
            heads_reg      <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        cls_reg        <= cls_next;
        count_reg      <= count_next;
        round_reg      <= round_next;
        at_reg         <= at_next;
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        hit_reg        <= hit_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while a beat is in progress");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (idx_reg >= n_reg) && (idx_reg <= 5'(NUM_CLASSES)))
        else $error("list search class out of range");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (heap_top_reg <= GW'(POOL_GRANULES)) && (heap_total_reg == heap_top_reg))
        else $error("backing region overrun");

    a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHAIN) && (idx_reg < count_reg) |-> cur_reg < pool_start_reg)
        else $error("chain write past carved blocks");
`endif

endmodule

FILE: tb/sv/tb_size_class_free_list_allocator.sv
// Testbench for the size class free list allocator: directed and random alloc/free beats.
`timescale 1ns / 1ps

module tb_size_class_free_list_allocator;
    import scfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [14:0] addr;
        logic [1:0]  status;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int            heads [NUM_CLASSES];
    int            links [POOL_GRANULES];
    int            pool_s, pool_e, heap_used, heap_taken;
    alloc_result_t expected_results[$];
    int            live_addr[$];
    int            live_size[$];
    int            errors = 0;
    int            idle_cycles = 0;
    bit            gaps_on = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    size_class_free_list_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic void push_free(input int cls, input int g);
        links[g] = heads[cls];
        heads[cls] = g;
    endfunction

    function automatic bit carve_pool(input int n, inout int count, output int at);
        int total, left, extra, get, h;
        bit found;
        at = 0;
        for (int round = 0; round < 4; round++)
        begin
            total = n * count;
            left = (pool_e >= pool_s) ? pool_e - pool_s : 0;
            if (left >= total)
            begin
                at = pool_s;
                pool_s += total;
                return 1'b1;
            end
            if (left >= n)
            begin
                count = left / n;
                at = pool_s;
                pool_s += n * count;
                return 1'b1;
            end
            extra = (((heap_taken * GRANULE_BYTES) >> 4) + GRANULE_BYTES - 1) / GRANULE_BYTES;
            get = 2 * total + extra;
            if (left > 0)
                push_free(left - 1, pool_s);
            pool_s = pool_e;
            if (get <= POOL_GRANULES - heap_used)
            begin
                pool_s = heap_used;
                heap_used += get;
                pool_e = pool_s + get;
                heap_taken += get;
                continue;
            end
            found = 1'b0;
            for (int c = n; c <= NUM_CLASSES; c++)
            begin
                h = heads[c - 1];
                if (h != EMPTY_MARK)
                begin
                    heads[c - 1] = links[h];
                    pool_s = h;
                    pool_e = h + c;
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                pool_s = 0;
                pool_e = 0;
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    // Advances the allocator state by one request and returns its answer.
    function automatic alloc_result_t allocator_answer(input bit cmd, input int size,
                                                       input int faddr);
        alloc_result_t r;
        int n, cls, g, count;
        r.addr = '0;
        r.status = ST_OK;
        if (size == 0 || size > MAX_BYTES)
        begin
            r.status = ST_BAD_SIZE;
            return r;
        end
        n = (size + GRANULE_BYTES - 1) / GRANULE_BYTES;
        cls = n - 1;
        if (cmd)
        begin
            g = faddr / GRANULE_BYTES;
            if (g < POOL_GRANULES)
                push_free(cls, g);
            return r;
        end
        g = heads[cls];
        if (g != EMPTY_MARK)
            heads[cls] = links[g];
        else
        begin
            count = REFILL_BLOCKS;
            if (!carve_pool(n, count, g))
            begin
                r.status = ST_OUT_OF_MEM;
                return r;
            end
            if (count > 1)
            begin
                heads[cls] = g + n;
                for (int i = 1; i < count; i++)
                    links[g + i * n] = (i == count - 1) ? EMPTY_MARK : g + (i + 1) * n;
            end
        end
        r.addr = 15'(g * GRANULE_BYTES);
        return r;
    endfunction

    task automatic send_beat(input bit cmd, input int size, input int faddr);
        alloc_result_t r;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {1'b0, 15'(faddr), 8'(size)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = allocator_answer(cmd, size, faddr);
        expected_results.push_back(r);
        if (!cmd && r.status == ST_OK)
        begin
            live_addr.push_back(r.addr);
            live_size.push_back(size);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic alloc_beat(input int size);
        send_beat(1'b0, size, $urandom_range(0, 32767));
    endtask

    task automatic free_live();
        int k;
        if (live_addr.size() == 0)
            return;
        k = $urandom_range(0, live_addr.size() - 1);
        send_beat(1'b1, live_size[k], live_addr[k] | $urandom_range(0, 7));
        live_addr.delete(k);
        live_size.delete(k);
    endtask

    task automatic test_bad_size();
        alloc_beat(0);
        alloc_beat(129);
        alloc_beat(255);
        send_beat(1'b1, 0, 32767);
        send_beat(1'b1, 200, 0);
    endtask

    task automatic test_size_extremes();
        alloc_beat(1);
        alloc_beat(8);
        alloc_beat(9);
        alloc_beat(64);
        alloc_beat(127);
        alloc_beat(128);
        free_live();
        free_live();
        send_beat(1'b1, 128, 32767);
        alloc_beat(128);
    endtask

    task automatic test_double_free();
        alloc_beat(16);
        send_beat(1'b1, 16, live_addr[live_addr.size() - 1]);
        send_beat(1'b1, 16, live_addr[live_addr.size() - 1]);
        live_addr.pop_back();
        live_size.pop_back();
        alloc_beat(16);
        alloc_beat(16);
        send_beat(1'b1, 24, 0);
    endtask

    // Drains the backing region so that leftovers, list search and out of memory occur.
    task automatic test_exhaust();
        for (int i = 0; i < 500; i++)
            alloc_beat(($urandom_range(0, 1) != 0) ? 128 : $urandom_range(1, 128));
        for (int i = 0; i < 150; i++)
            free_live();
        for (int i = 0; i < 200; i++)
            alloc_beat($urandom_range(1, 128));
    endtask

    task automatic test_random_mix(input int beats);
        int pick;
        for (int i = 0; i < beats; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_beat($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 32767));
            else if (pick == 1)
                send_beat(1'b1, $urandom_range(1, 128), $urandom_range(0, 32767) & ~7);
            else if (pick < 10 && live_addr.size() > 0)
                free_live();
            else
                alloc_beat($urandom_range(1, 128));
        end
    endtask

    task automatic test_drain_pause();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        test_random_mix(50);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
            heads[i] = EMPTY_MARK;
        pool_s = 0;
        pool_e = 0;
        heap_used = 0;
        heap_taken = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_bad_size();
        test_size_extremes();
        test_double_free();
        test_exhaust();
        test_drain_pause();
        test_random_mix(700);
        gaps_on = 1'b0;
        test_random_mix(400);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("size_class_free_list_allocator regression: pass");
        else
            $display("size_class_free_list_allocator regression: fail");
        $finish;
    end

    initial
    begin
        forever
        begin
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report("unexpected beat", m_axis_tdata, 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[14:0] != want.addr)
                    report("block_addr", m_axis_tdata[14:0], want.addr);
                if (m_axis_tdata[16:15] != want.status)
                    report("status", m_axis_tdata[16:15], want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("size_class_free_list_allocator regression: fail");
            $finish;
        end
    end

endmodule
